>>> src/ofrs_pkg.sv
// ---------------------------------------------------------------------------
// OLED framebuffer refresh streamer: shared definitions
// Panel defaults, command and register codes, state types and the
// controller init command list.
// ---------------------------------------------------------------------------
package ofrs_pkg;

  localparam int unsigned PanelWidthDef  = 128;
  localparam int unsigned PanelHeightDef = 64;

  localparam int unsigned InitLen     = 25;
  localparam int unsigned InitScanPos = 13;
  localparam int unsigned InitPinsPos = 15;

  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;

  localparam logic [7:0] ComScanRst = 8'd200;
  localparam logic [7:0] ComPinsRst = 8'd18;

  typedef enum logic [2:0] {
    CMD_SET_PIXEL   = 3'd0,
    CMD_FILL        = 3'd1,
    CMD_START_INIT  = 3'd2,
    CMD_START_FRAME = 3'd3,
    CMD_NEXT_BYTE   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_RMW   = 2'd2,
    ST_DATA  = 2'd3
  } state_e;

  typedef enum logic {
    CFG_COM_SCAN = 1'b0,
    CFG_COM_PINS = 1'b1
  } cfg_idx_e;

  // Fixed part of the init list; the two register slots read as zero here.
  function automatic logic [7:0] init_byte(logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'hAE;
      5'd1:    b = 8'hD5;
      5'd2:    b = 8'h80;
      5'd3:    b = 8'hA8;
      5'd4:    b = 8'h3F;
      5'd5:    b = 8'hD3;
      5'd6:    b = 8'h00;
      5'd7:    b = 8'h40;
      5'd8:    b = 8'h8D;
      5'd9:    b = 8'h14;
      5'd10:   b = 8'h20;
      5'd11:   b = 8'h00;
      5'd12:   b = 8'hA1;
      5'd14:   b = 8'hDA;
      5'd16:   b = 8'h81;
      5'd17:   b = 8'hCF;
      5'd18:   b = 8'hD9;
      5'd19:   b = 8'hF1;
      5'd20:   b = 8'hDB;
      5'd21:   b = 8'h40;
      5'd22:   b = 8'hA4;
      5'd23:   b = 8'hA6;
      5'd24:   b = 8'hAF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> src/oled_framebuffer_refresh_streamer.sv
// ---------------------------------------------------------------------------
// OLED framebuffer refresh streamer
// Page-organized monochrome framebuffer in one synchronous RAM, with pixel
// writes, fills and a panel byte stream for a page-mode OLED controller.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transfer: tuser is the command (set pixel,
//   fill, start init, start frame, next byte), tdata holds x, y and on.
//   m_axis returns one panel byte per next-byte request while a stream runs;
//   tuser flags data versus command and chip-select release, tlast marks the
//   last data byte of the frame. The cfg channel writes the COM scan and COM
//   pins bytes of the init list; it is always ready.
// Timing:
//   Commands without a result and next-byte requests for command bytes leave
//   the block idle; the command byte is valid in the cycle after its request.
//   Pixel writes read the RAM, then modify and write back in the RMW state. A
//   data byte is read from the RAM into its read register, then copied into
//   the output register in the DATA state. Fill and init start sweep all
//   PANEL_WIDTH * ceil(PANEL_HEIGHT/8) RAM bytes, one byte per cycle.
//   A result waits in the output register; a new command is taken only while
//   that register is empty or transfers in the same cycle, so a stalled
//   receiver stalls the input side after one result.
// Reset:
//   Control registers and cfg bytes return to their defaults and the RAM is cleared by a sweep of
//   the same length as a fill; no command is taken until it finishes.
// ---------------------------------------------------------------------------
module oled_framebuffer_refresh_streamer #(
  parameter int unsigned PANEL_WIDTH  = ofrs_pkg::PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = ofrs_pkg::PanelHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [11:0] x, [23:12] y, [24] on, [31:25] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  // panel byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [0] is_data, [1] cs_release
  output logic        m_axis_tlast,   // frame_end
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned StorePages = (PANEL_HEIGHT + 7) / 8;
  localparam int unsigned StoreSize  = PANEL_WIDTH * StorePages;
  localparam int unsigned AddrW      = $clog2(StoreSize);
  localparam int unsigned PageCount  = PANEL_HEIGHT / 8;
  localparam int unsigned PageW      = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int unsigned OffMax     = (PANEL_WIDTH > ofrs_pkg::InitLen) ?
                                       PANEL_WIDTH : ofrs_pkg::InitLen;
  localparam int unsigned OffW       = $clog2(OffMax);

  // Storage
  logic [7:0] mem [StoreSize];
  logic [7:0] rd_data_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic             mem_re;
  logic [AddrW-1:0] mem_ra;

  // Control state
  ofrs_pkg::state_e state_q, state_d;
  ofrs_pkg::phase_e phase_q, phase_d;
  logic             active_q, active_d;
  logic [PageW-1:0] page_q, page_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             fill_q, fill_d;
  logic [7:0]       com_scan_q, com_pins_q;

  // Pixel write context
  logic [AddrW-1:0] pix_addr_q;
  logic [2:0]       pix_bit_q;
  logic             pix_on_q;

  // Output register
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [1:0] out_user_q, out_user_d;
  logic       out_last_q, out_last_d;

  // Input decode
  ofrs_pkg::cmd_e   cmd;
  logic [11:0]      in_x, in_y;
  logic             in_on;
  logic             accept;
  logic             pix_in_panel;
  logic [AddrW-1:0] pix_addr;
  logic [AddrW-1:0] stream_addr;
  logic             clr_last;
  logic [7:0]       rmw_byte;

  assign cmd    = ofrs_pkg::cmd_e'(s_axis_tuser);
  assign in_x   = s_axis_tdata[11:0];
  assign in_y   = s_axis_tdata[23:12];
  assign in_on  = s_axis_tdata[24];

  // take a command in idle while the output register is empty or drains this cycle
  assign s_axis_tready = (state_q == ofrs_pkg::ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign pix_in_panel = !in_x[11] && (in_x[10:0] < 11'(PANEL_WIDTH)) &&
                        !in_y[11] && (in_y[10:0] < 11'(PANEL_HEIGHT));
  assign pix_addr     = AddrW'(int'(in_y[10:3]) * PANEL_WIDTH + int'(in_x[10:0]));
  assign stream_addr  = AddrW'(int'(page_q) * PANEL_WIDTH + int'(off_q));
  assign clr_last     = (clr_addr_q == AddrW'(StoreSize - 1));

  always_comb begin
    rmw_byte = rd_data_q;
    rmw_byte[pix_bit_q] = pix_on_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ofrs_pkg::ST_CLEAR: begin
        if (clr_last) state_d = ofrs_pkg::ST_IDLE;
      end
      ofrs_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (cmd)
            ofrs_pkg::CMD_SET_PIXEL: begin
              if (pix_in_panel) state_d = ofrs_pkg::ST_RMW;
            end
            ofrs_pkg::CMD_FILL, ofrs_pkg::CMD_START_INIT: state_d = ofrs_pkg::ST_CLEAR;
            ofrs_pkg::CMD_NEXT_BYTE: begin
              if (active_q && phase_q == ofrs_pkg::PH_DATA) state_d = ofrs_pkg::ST_DATA;
            end
            default: state_d = ofrs_pkg::ST_IDLE;
          endcase
        end
      end
      ofrs_pkg::ST_RMW:  state_d = ofrs_pkg::ST_IDLE;
      ofrs_pkg::ST_DATA: state_d = ofrs_pkg::ST_IDLE;
      default:           state_d = ofrs_pkg::ST_IDLE;
    endcase
  end

  // Outputs: RAM ports, stream sequencing, output register
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = clr_addr_q;
    mem_wd     = {8{fill_q}};
    mem_re     = 1'b0;
    mem_ra     = stream_addr;
    phase_d    = phase_q;
    active_d   = active_q;
    page_d     = page_q;
    off_d      = off_q;
    clr_addr_d = clr_addr_q;
    fill_d     = fill_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_byte_d = out_byte_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ofrs_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
      ofrs_pkg::ST_RMW: begin
        mem_we = 1'b1;
        mem_wa = pix_addr_q;
        mem_wd = rmw_byte;
      end
      ofrs_pkg::ST_DATA: begin
        out_vld_d  = 1'b1;
        out_byte_d = rd_data_q;
      end
      default: begin
      end
    endcase

    if (accept) begin
      priority case (cmd)
        ofrs_pkg::CMD_SET_PIXEL: begin
          mem_re = pix_in_panel;
          mem_ra = pix_addr;
        end
        ofrs_pkg::CMD_FILL: begin
          fill_d     = in_on;
          clr_addr_d = '0;
        end
        ofrs_pkg::CMD_START_INIT: begin
          fill_d     = 1'b0;
          clr_addr_d = '0;
          active_d   = 1'b1;
          phase_d    = ofrs_pkg::PH_INIT;
          page_d     = '0;
          off_d      = '0;
        end
        ofrs_pkg::CMD_START_FRAME: begin
          active_d = 1'b1;
          phase_d  = ofrs_pkg::PH_CMD;
          page_d   = '0;
          off_d    = '0;
        end
        ofrs_pkg::CMD_NEXT_BYTE: begin
          if (active_q) begin
            out_user_d = 2'b01;
            out_last_d = 1'b0;
            priority case (phase_q)
              ofrs_pkg::PH_INIT: begin
                out_vld_d  = 1'b1;
                out_user_d = 2'b10;
                if (off_q == OffW'(ofrs_pkg::InitScanPos)) out_byte_d = com_scan_q;
                else if (off_q == OffW'(ofrs_pkg::InitPinsPos)) out_byte_d = com_pins_q;
                else out_byte_d = ofrs_pkg::init_byte(off_q[4:0]);
                if (off_q == OffW'(ofrs_pkg::InitLen - 1)) begin
                  phase_d = ofrs_pkg::PH_CMD;
                  page_d  = '0;
                  off_d   = '0;
                end else begin
                  off_d = off_q + OffW'(1);
                end
              end
              ofrs_pkg::PH_CMD: begin
                out_vld_d  = 1'b1;
                out_user_d = 2'b10;
                if (off_q == OffW'(0)) out_byte_d = ofrs_pkg::CmdPageBase + 8'(page_q);
                else if (off_q == OffW'(1)) out_byte_d = ofrs_pkg::CmdColLow;
                else out_byte_d = ofrs_pkg::CmdColHigh;
                if (off_q == OffW'(2)) begin
                  phase_d = ofrs_pkg::PH_DATA;
                  off_d   = '0;
                end else begin
                  off_d = off_q + OffW'(1);
                end
              end
              ofrs_pkg::PH_DATA: begin
                // byte itself arrives from the RAM next cycle
                mem_re = 1'b1;
                mem_ra = stream_addr;
                if (off_q == OffW'(PANEL_WIDTH - 1)) begin
                  out_user_d = 2'b11;
                  off_d      = '0;
                  if (page_q == PageW'(PageCount - 1)) begin
                    out_last_d = 1'b1;
                    active_d   = 1'b0;
                    phase_d    = ofrs_pkg::PH_INIT;
                    page_d     = '0;
                  end else begin
                    phase_d = ofrs_pkg::PH_CMD;
                    page_d  = page_q + PageW'(1);
                  end
                end else begin
                  off_d = off_q + OffW'(1);
                end
              end
              default: begin
                out_vld_d  = 1'b1;
                out_byte_d = 8'h00;
                out_user_d = 2'b00;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ofrs_pkg::ST_CLEAR;
      phase_q    <= ofrs_pkg::PH_INIT;
      active_q   <= 1'b0;
      page_q     <= '0;
      off_q      <= '0;
      clr_addr_q <= '0;
      fill_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      com_scan_q <= ofrs_pkg::ComScanRst;
      com_pins_q <= ofrs_pkg::ComPinsRst;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      active_q   <= active_d;
      page_q     <= page_d;
      off_q      <= off_d;
      clr_addr_q <= clr_addr_d;
      fill_q     <= fill_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i) begin
        unique case (ofrs_pkg::cfg_idx_e'(cfg_index_i))
          ofrs_pkg::CFG_COM_SCAN: com_scan_q <= cfg_data_i;
          ofrs_pkg::CFG_COM_PINS: com_pins_q <= cfg_data_i;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
    if (accept) begin
      pix_addr_q <= pix_addr;
      pix_bit_q  <= in_y[2:0];
      pix_on_q   <= in_on;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> verif/ofrs_stream_checker.sv
// ---------------------------------------------------------------------------
// OLED framebuffer streamer: scoreboard
// Watches the command, panel byte and register channels, tracks its own
// copy of the framebuffer and stream position, and compares every panel
// byte field by field with the byte it predicts.
// ---------------------------------------------------------------------------
module ofrs_stream_checker
  import ofrs_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = PanelHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [31:0] cmd_data_i,
  input  logic [2:0]  cmd_user_i,
  // panel byte channel
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,
  input  logic [1:0]  byte_user_i,
  input  logic        byte_last_i,
  // register writes
  input  logic        reg_valid_i,
  input  logic        reg_ready_i,
  input  logic        reg_index_i,
  input  logic [7:0]  reg_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned bytes_o,
  output int unsigned frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PageCount  = PANEL_HEIGHT / 8;
  localparam int unsigned StoreBytes = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int unsigned MaxReports = 40;

  // Controller init sequence, first byte in the low bits; the COM scan and
  // COM pins slots are placeholders, filled from the registers.
  localparam logic [InitLen*8-1:0] InitSeq = {
    8'hAF, 8'hA6, 8'hA4, 8'h40, 8'hDB, 8'hF1, 8'hD9, 8'hCF, 8'h81, 8'h00,
    8'hDA, 8'h00, 8'hA1, 8'h00, 8'h20, 8'h14, 8'h8D, 8'h40, 8'h00, 8'hD3,
    8'h3F, 8'hA8, 8'h80, 8'hD5, 8'hAE
  };

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       cs_rel;
    logic       fend;
  } panel_byte_t;

  logic [7:0]        pix_mem [StoreBytes];
  logic [7:0]        scan_q;
  logic [7:0]        pins_q;
  logic              streaming;
  phase_e            phase_q;
  logic [2:0]        page_q;
  logic [7:0]        offset_q;
  panel_byte_t       panel_bytes_due [$];
  panel_byte_t       due;
  panel_byte_t       seen;
  panel_byte_t       made_byte;
  bit                made;
  logic signed [11:0] px;
  logic signed [11:0] py;
  int                sx;
  int                sy;
  int unsigned       errs;
  int unsigned       n_bytes;
  int unsigned       n_frames;

  task automatic report_field(string field, int unsigned want, int unsigned got);
    errs++;
    if (errs <= MaxReports) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Produce the next panel byte and advance the stream position.
  task automatic predict_panel_byte(output bit produced, output panel_byte_t b);
    int unsigned slot;
    produced = streaming;
    b = '0;
    if (streaming) begin
      case (phase_q)
        PH_INIT: begin
          slot = (offset_q >= InitLen) ? InitLen - 1 : offset_q;
          if (slot == InitScanPos) b.value = scan_q;
          else if (slot == InitPinsPos) b.value = pins_q;
          else b.value = InitSeq[slot*8 +: 8];
          b.cs_rel = 1'b1;
          offset_q = 8'(slot + 1);
          if (slot + 1 >= InitLen) begin
            phase_q  = PH_CMD;
            page_q   = '0;
            offset_q = '0;
          end
        end
        PH_CMD: begin
          case (offset_q)
            8'd0:    b.value = CmdPageBase + 8'(page_q);
            8'd1:    b.value = CmdColLow;
            default: b.value = CmdColHigh;
          endcase
          b.cs_rel = 1'b1;
          if (offset_q >= 8'd2) begin
            phase_q  = PH_DATA;
            offset_q = '0;
          end else begin
            offset_q++;
          end
        end
        default: begin
          // data bytes come from the store as it stands right now
          slot = page_q * PANEL_WIDTH + offset_q;
          b.value   = (slot < StoreBytes) ? pix_mem[slot] : '0;
          b.is_data = 1'b1;
          if (int'(offset_q) + 1 >= int'(PANEL_WIDTH)) begin
            b.cs_rel = 1'b1;
            offset_q = '0;
            if (int'(page_q) + 1 >= int'(PageCount)) begin
              b.fend    = 1'b1;
              streaming = 1'b0;
              phase_q   = PH_INIT;
              page_q    = '0;
            end else begin
              page_q++;
              phase_q = PH_CMD;
            end
          end else begin
            offset_q++;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreBytes; i++) pix_mem[i] = '0;
      scan_q    = ComScanRst;
      pins_q    = ComPinsRst;
      streaming = 1'b0;
      phase_q   = PH_INIT;
      page_q    = '0;
      offset_q  = '0;
      panel_bytes_due.delete();
      errs      = 0;
      n_bytes   = 0;
      n_frames  = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      bytes_o      <= 0;
      frames_o     <= 0;
    end else begin
      // outputs first: a byte leaving now belongs to an earlier request
      if (byte_valid_i && byte_ready_i) begin
        seen.value   = byte_data_i;
        seen.is_data = byte_user_i[0];
        seen.cs_rel  = byte_user_i[1];
        seen.fend    = byte_last_i;
        if (panel_bytes_due.size() == 0) begin
          errs++;
          if (errs <= MaxReports) begin
            $display("%0t: panel byte %02h with no request waiting, expected none",
                     $time, byte_data_i);
          end
        end else begin
          due = panel_bytes_due.pop_front();
          n_bytes++;
          if (due.fend) n_frames++;
          if (seen.value !== due.value) report_field("out_byte", due.value, seen.value);
          if (seen.is_data !== due.is_data) report_field("is_data", due.is_data, seen.is_data);
          if (seen.cs_rel !== due.cs_rel) report_field("cs_release", due.cs_rel, seen.cs_rel);
          if (seen.fend !== due.fend) report_field("frame_end", due.fend, seen.fend);
        end
      end

      if (reg_valid_i && reg_ready_i) begin
        case (cfg_idx_e'(reg_index_i))
          CFG_COM_SCAN: scan_q = reg_data_i;
          CFG_COM_PINS: pins_q = reg_data_i;
          default: ;
        endcase
      end

      if (cmd_valid_i && cmd_ready_i) begin
        px = cmd_data_i[11:0];
        py = cmd_data_i[23:12];
        sx = px;
        sy = py;
        case (cmd_user_i)
          CMD_SET_PIXEL: begin
            // drop writes outside the panel
            if (sx >= 0 && sx < int'(PANEL_WIDTH) && sy >= 0 && sy < int'(PANEL_HEIGHT)) begin
              if (cmd_data_i[24]) pix_mem[(sy / 8) * PANEL_WIDTH + sx] |= 8'(1 << (sy % 8));
              else pix_mem[(sy / 8) * PANEL_WIDTH + sx] &= ~8'(1 << (sy % 8));
            end
          end
          CMD_FILL: begin
            for (int i = 0; i < StoreBytes; i++) pix_mem[i] = {8{cmd_data_i[24]}};
          end
          CMD_START_INIT: begin
            for (int i = 0; i < StoreBytes; i++) pix_mem[i] = '0;
            streaming = 1'b1;
            phase_q   = PH_INIT;
            page_q    = '0;
            offset_q  = '0;
          end
          CMD_START_FRAME: begin
            streaming = 1'b1;
            phase_q   = PH_CMD;
            page_q    = '0;
            offset_q  = '0;
          end
          CMD_NEXT_BYTE: begin
            predict_panel_byte(made, made_byte);
            if (made) panel_bytes_due.push_back(made_byte);
          end
          default: ;
        endcase
      end

      mismatches_o <= errs;
      pending_o    <= panel_bytes_due.size();
      bytes_o      <= n_bytes;
      frames_o     <= n_frames;
    end
  end

endmodule

>>> verif/oled_framebuffer_refresh_streamer_tb.sv
// ---------------------------------------------------------------------------
// OLED framebuffer streamer: testbench top
// Drives pixel writes, fills, init and frame starts and byte requests with
// random gaps on both channels, a long receiver hold-off and a gap-free
// stretch, over several register settings; the scoreboard checks every
// panel byte.
// ---------------------------------------------------------------------------
module oled_framebuffer_refresh_streamer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofrs_pkg::*;

  localparam int unsigned Width         = 128;
  localparam int unsigned Height        = 64;
  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned IdlePct       = 28;
  localparam int unsigned FrameBytes    = (Height / 8) * (3 + Width);
  localparam int unsigned SweepCycles   = Width * ((Height + 7) / 8);
  localparam int unsigned SettleCycles  = SweepCycles + 64;
  localparam int unsigned HoldAfter     = 200;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 4 * (SweepCycles + HoldCycles);
  localparam int unsigned ShortMax      = 160;
  localparam int unsigned QuietLen      = 100;
  localparam int unsigned Phase0Items   = 1300;
  localparam int unsigned Phase1Items   = 1400;
  localparam int unsigned Phase2Items   = 1500;
  localparam logic [2:0]  OpUnusedLo    = 3'd5;
  localparam logic [2:0]  OpUnusedHi    = 3'd7;
  localparam logic [11:0] XLast         = 12'(Width - 1);
  localparam logic [11:0] YLast         = 12'(Height - 1);
  localparam logic [11:0] CoordMin      = 12'h800;
  localparam logic [11:0] CoordMax      = 12'h7FF;
  localparam logic [11:0] CoordNeg1     = 12'hFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  logic        no_idle;
  int unsigned items_sent;
  int unsigned n_pixels;
  int unsigned n_sweeps;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned bytes_seen;
  int unsigned frames_seen;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  oled_framebuffer_refresh_streamer #(
    .PANEL_WIDTH (Width),
    .PANEL_HEIGHT(Height)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  ofrs_stream_checker #(
    .PANEL_WIDTH (Width),
    .PANEL_HEIGHT(Height)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_i (s_axis_tready),
    .cmd_data_i  (s_axis_tdata),
    .cmd_user_i  (s_axis_tuser),
    .byte_valid_i(m_axis_tvalid),
    .byte_ready_i(m_axis_tready),
    .byte_data_i (m_axis_tdata),
    .byte_user_i (m_axis_tuser),
    .byte_last_i (m_axis_tlast),
    .reg_valid_i (cfg_valid_i),
    .reg_ready_i (cfg_ready_o),
    .reg_index_i (cfg_index_i),
    .reg_data_i  (cfg_data_i),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .bytes_o     (bytes_seen),
    .frames_o    (frames_seen)
  );

  // One command transfer, with random gaps ahead of it.
  task automatic send(logic [2:0] op, logic [11:0] px, logic [11:0] py, logic lit);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lit, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op <= CMD_NEXT_BYTE) items_sent++;
    if (op == CMD_SET_PIXEL) n_pixels++;
    if (op == CMD_FILL || op == CMD_START_INIT) n_sweeps++;
  endtask

  task automatic program_regs(logic [7:0] scan, logic [7:0] pins);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_COM_SCAN;
    cfg_data_i  <= scan;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_COM_PINS;
    cfg_data_i  <= pins;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every expected byte, then let a possible sweep finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Start a stream and request bytes, mixed with writes and noise.
  task automatic run_stream(cmd_e kick, bit whole, int unsigned n_short);
    int unsigned n_req;
    int unsigned done;
    int unsigned pick;
    n_req = whole ? FrameBytes + $urandom_range(2) : n_short;
    if (whole && kick == CMD_START_INIT) n_req += InitLen;
    send(kick, 12'($urandom), 12'($urandom), 1'($urandom));
    done = 0;
    while (done < n_req) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send(CMD_SET_PIXEL, 12'($urandom_range(Width - 1)), 12'($urandom_range(Height - 1)),
             1'($urandom));
      end else if (pick < 14) begin
        send(CMD_SET_PIXEL, 12'($urandom), 12'($urandom), 1'($urandom));
      end else if (pick < 15) begin
        send(CMD_FILL, 12'($urandom), 12'($urandom), 1'($urandom));
      end else if (pick < 18) begin
        send(3'($urandom_range(OpUnusedHi, OpUnusedLo)), 12'($urandom), 12'($urandom),
             1'($urandom));
      end else if (pick < 20 && !whole) begin
        send($urandom_range(1) ? CMD_START_INIT : CMD_START_FRAME, 12'($urandom),
             12'($urandom), 1'($urandom));
      end else begin
        send(CMD_NEXT_BYTE, 12'($urandom), 12'($urandom), 1'($urandom));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_NEXT_BYTE;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_COM_SCAN;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    items_sent    = 0;
    n_pixels      = 0;
    n_sweeps      = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(8'h00, 8'hFF);

    // directed: idle request, unknown codes, corners, out-of-panel writes,
    // restarts mid-stream and both fills
    send(CMD_NEXT_BYTE, '0, '0, 1'b0);
    send(OpUnusedLo, CoordNeg1, CoordNeg1, 1'b1);
    send(OpUnusedHi, '0, '0, 1'b0);
    send(CMD_SET_PIXEL, '0, '0, 1'b1);
    send(CMD_SET_PIXEL, '0, 12'd7, 1'b1);
    send(CMD_SET_PIXEL, XLast, YLast, 1'b1);
    send(CMD_SET_PIXEL, CoordNeg1, '0, 1'b1);
    send(CMD_SET_PIXEL, 12'(Width), '0, 1'b1);
    send(CMD_SET_PIXEL, '0, 12'(Height), 1'b1);
    send(CMD_SET_PIXEL, CoordMin, CoordMin, 1'b1);
    send(CMD_SET_PIXEL, CoordMax, CoordMax, 1'b1);
    send(CMD_SET_PIXEL, '0, 12'd7, 1'b0);
    send(CMD_START_FRAME, '0, '0, 1'b0);
    repeat (5) send(CMD_NEXT_BYTE, '0, '0, 1'b0);
    send(CMD_START_FRAME, '0, '0, 1'b0);
    send(CMD_NEXT_BYTE, '0, '0, 1'b0);
    send(CMD_START_INIT, '0, '0, 1'b0);
    repeat (2) send(CMD_NEXT_BYTE, '0, '0, 1'b0);
    send(CMD_FILL, '0, '0, 1'b1);
    send(CMD_NEXT_BYTE, '0, '0, 1'b0);
    send(CMD_FILL, '0, '0, 1'b0);

    // one complete init stream, then short random streams
    run_stream(CMD_START_INIT, 1'b1, 0);
    while (items_sent < Phase0Items) begin
      run_stream(cmd_e'($urandom_range(1) ? CMD_START_INIT : CMD_START_FRAME), 1'b0,
                 $urandom_range(ShortMax, 1));
    end
    drain();

    program_regs(8'hFF, 8'h00);
    while (items_sent < Phase1Items) begin
      run_stream(cmd_e'($urandom_range(1) ? CMD_START_INIT : CMD_START_FRAME), 1'b0,
                 $urandom_range(ShortMax, 1));
    end
    drain();

    // random register values; begin with a gap-free stretch on both sides
    program_regs(8'($urandom), 8'($urandom));
    no_idle <= 1'b1;
    run_stream(CMD_START_INIT, 1'b0, QuietLen);
    no_idle <= 1'b0;
    while (items_sent < Phase2Items) begin
      run_stream(cmd_e'($urandom_range(1) ? CMD_START_INIT : CMD_START_FRAME), 1'b0,
                 $urandom_range(ShortMax, 1));
    end
    drain();

    $display("Sent %0d commands (%0d pixel writes, %0d store sweeps) over three register settings;",
             items_sent, n_pixels, n_sweeps);
    $display("compared %0d panel bytes, %0d of them closing a frame.", bytes_seen, frames_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : byte_sink
    int unsigned taken;
    bit          held;
    taken         = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      // hold off once, long enough to back up the command side
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> oled_framebuffer_refresh_streamer.f
src/ofrs_pkg.sv
src/oled_framebuffer_refresh_streamer.sv
verif/ofrs_stream_checker.sv
verif/oled_framebuffer_refresh_streamer_tb.sv
